/* rtl/dsa_pkg.sv */
`default_nettype none

package dsa_pkg;

   // Step addresses of the control program
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MUL      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_EXIT = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DIV      = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ROUND    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DONE     = 3'd5;

   // Datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_W-1:0] OP_ROUND = 3'd4;
   localparam logic [OP_W-1:0] OP_EMIT  = 3'd5;

   // Branch conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS = 3'd0;
   localparam logic [COND_W-1:0] COND_REQ    = 3'd1;
   localparam logic [COND_W-1:0] COND_EQ     = 3'd2;
   localparam logic [COND_W-1:0] COND_STOP   = 3'd3;
   localparam logic [COND_W-1:0] COND_OVF    = 3'd4;
   localparam logic [COND_W-1:0] COND_FREE   = 3'd5;

   // Division of a 33-bit value by ten: (t * RECIP) >> SHIFT, exact below 2**34
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;
   // 2**32 = 10 * LIMB_Q + 6
   localparam logic [31:0] LIMB_Q      = 32'd429496729;
   localparam logic [3:0]  HALF_DIGIT  = 4'd5;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] tgt;
      logic [STEP_W-1:0] nxt;
   } ucode_word_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            fire;
   } dp_ctrl_type;

   typedef struct packed {
      logic eq;
      logic mul_ovf;
      logic ovf;
   } dp_stat_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      case (step)
         STEP_IDLE:     w = '{op: OP_LOAD,  cond: COND_REQ,    tgt: STEP_MUL,
                              nxt: STEP_IDLE};
         STEP_MUL:      w = '{op: OP_MUL,   cond: COND_STOP,   tgt: STEP_MUL_EXIT,
                              nxt: STEP_MUL};
         STEP_MUL_EXIT: w = '{op: OP_NOP,   cond: COND_OVF,    tgt: STEP_DIV,
                              nxt: STEP_DONE};
         STEP_DIV:      w = '{op: OP_DIV,   cond: COND_EQ,     tgt: STEP_ROUND,
                              nxt: STEP_DIV};
         STEP_ROUND:    w = '{op: OP_ROUND, cond: COND_ALWAYS, tgt: STEP_DONE,
                              nxt: STEP_DONE};
         STEP_DONE:     w = '{op: OP_EMIT,  cond: COND_FREE,   tgt: STEP_IDLE,
                              nxt: STEP_DONE};
         default:       w = '{op: OP_NOP,   cond: COND_ALWAYS, tgt: STEP_IDLE,
                              nxt: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/decimal_scale_align_top.sv */
// Decimal operand scale alignment.
// req channel: two decimal operands (96-bit mantissa, sign, scale each).
// rsp channel: both mantissas on one common scale, the signs, the common
// scale and a flag that is set when the division and rounding path ran.
// One item is worked on at a time; req_stall stays high until the result
// of the current item has been moved into the output register.
// When k multiply-by-ten steps bring the scales together, k is the scale
// gap (up to 28). When a multiply overflows after k steps, the
// larger-scale mantissa is divided down d steps instead; each divide step
// covers L = ceil(MANT_BITS / 32) 32-bit limbs, and the divide-by-ten
// unit takes one limb per cycle.
// A short program in a constant table sequences the datapath, one control
// word per cycle. Reset clears the step counter and the output valid.
// While rsp_stall is high the result beat holds; the block stays at its
// final step until the output register frees up.

`default_nettype none

module decimal_scale_align_top #(
   parameter int MANT_BITS = 96,
   parameter int MAX_SCALE = 28
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_mant_a_lo,
   input  wire  [31:0] req_mant_a_hi,
   input  wire  [4:0]  req_scale_a,
   input  wire         req_sign_a,
   input  wire  [63:0] req_mant_b_lo,
   input  wire  [31:0] req_mant_b_hi,
   input  wire  [4:0]  req_scale_b,
   input  wire         req_sign_b,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_out_a_lo,
   output logic [31:0] rsp_out_a_hi,
   output logic        rsp_out_a_sign,
   output logic [63:0] rsp_out_b_lo,
   output logic [31:0] rsp_out_b_hi,
   output logic        rsp_out_b_sign,
   output logic [4:0]  rsp_common_scale,
   output logic        rsp_was_rounded
);
   import dsa_pkg::*;

   logic [STEP_W-1:0]    step_ff, step_in;
   ucode_word_type       uw;
   logic                 cond_true;
   logic                 out_free;
   dp_ctrl_type          ctrl;
   dp_stat_type          stat;

   logic [MANT_BITS-1:0] res_mant_a, res_mant_b;
   logic [4:0]           res_scale;
   logic                 res_sign_a, res_sign_b;
   logic [127:0]         res_a_ext, res_b_ext;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          a_lo_ff, b_lo_ff;
   logic [31:0]          a_hi_ff, b_hi_ff;
   logic                 a_sign_ff, b_sign_ff, rounded_ff;
   logic [4:0]           scale_ff;
   logic                 emit;

   assign uw       = ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (uw.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_REQ:    cond_true = req_valid;
         COND_EQ:     cond_true = stat.eq;
         COND_STOP:   cond_true = stat.eq || stat.mul_ovf;
         COND_OVF:    cond_true = stat.ovf;
         COND_FREE:   cond_true = out_free;
         default:     cond_true = 1'b0;
      endcase
   end

   assign step_in = cond_true ? uw.tgt : uw.nxt;

   // load only on an accepted beat; other ops gate themselves
   assign ctrl.op   = uw.op;
   assign ctrl.fire = (uw.op == OP_LOAD) ? req_valid : 1'b1;

   assign req_stall = (step_ff != STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   dsa_datapath #(
      .MANT_BITS (MANT_BITS),
      .MAX_SCALE (MAX_SCALE)
   ) u_datapath (
      .clock        (clock),
      .ctrl         (ctrl),
      .stat         (stat),
      .in_mant_a_lo (req_mant_a_lo),
      .in_mant_a_hi (req_mant_a_hi),
      .in_scale_a   (req_scale_a),
      .in_sign_a    (req_sign_a),
      .in_mant_b_lo (req_mant_b_lo),
      .in_mant_b_hi (req_mant_b_hi),
      .in_scale_b   (req_scale_b),
      .in_sign_b    (req_sign_b),
      .res_mant_a   (res_mant_a),
      .res_mant_b   (res_mant_b),
      .res_scale    (res_scale),
      .res_sign_a   (res_sign_a),
      .res_sign_b   (res_sign_b)
   );

   assign res_a_ext = 128'(res_mant_a);
   assign res_b_ext = 128'(res_mant_b);
   assign emit      = (uw.op == OP_EMIT) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         a_lo_ff    <= res_a_ext[63:0];
         a_hi_ff    <= res_a_ext[95:64];
         a_sign_ff  <= res_sign_a;
         b_lo_ff    <= res_b_ext[63:0];
         b_hi_ff    <= res_b_ext[95:64];
         b_sign_ff  <= res_sign_b;
         scale_ff   <= res_scale;
         rounded_ff <= stat.ovf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_a_lo     = a_lo_ff;
   assign rsp_out_a_hi     = a_hi_ff;
   assign rsp_out_a_sign   = a_sign_ff;
   assign rsp_out_b_lo     = b_lo_ff;
   assign rsp_out_b_hi     = b_hi_ff;
   assign rsp_out_b_sign   = b_sign_ff;
   assign rsp_common_scale = scale_ff;
   assign rsp_was_rounded  = rounded_ff;

endmodule

`default_nettype wire

/* rtl/dsa_datapath.sv */
`default_nettype none

module dsa_datapath #(
   parameter int MANT_BITS = 96,
   parameter int MAX_SCALE = 28
) (
   input  wire                       clock,
   input  wire dsa_pkg::dp_ctrl_type ctrl,
   output dsa_pkg::dp_stat_type      stat,
   input  wire  [63:0]               in_mant_a_lo,
   input  wire  [31:0]               in_mant_a_hi,
   input  wire  [4:0]                in_scale_a,
   input  wire                       in_sign_a,
   input  wire  [63:0]               in_mant_b_lo,
   input  wire  [31:0]               in_mant_b_hi,
   input  wire  [4:0]                in_scale_b,
   input  wire                       in_sign_b,
   output logic [MANT_BITS-1:0]      res_mant_a,
   output logic [MANT_BITS-1:0]      res_mant_b,
   output logic [4:0]                res_scale,
   output logic                      res_sign_a,
   output logic                      res_sign_b
);
   import dsa_pkg::*;

   localparam int LIMBS = (MANT_BITS + 31) / 32;
   localparam int PAD_W = LIMBS * 32;
   localparam int IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int SW    = $clog2(MAX_SCALE + 1);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(LIMBS - 1);

   logic [MANT_BITS-1:0] mant_a_ff, mant_a_in, mant_b_ff, mant_b_in;
   logic [MANT_BITS-1:0] orig_a_ff, orig_a_in, orig_b_ff, orig_b_in;
   logic [SW-1:0]        scale_a_ff, scale_a_in, scale_b_ff, scale_b_in;
   logic [SW-1:0]        orig_sa_ff, orig_sa_in, orig_sb_ff, orig_sb_in;
   logic                 sign_a_ff, sign_a_in, sign_b_ff, sign_b_in;
   logic                 ovf_ff, ovf_in;
   logic [3:0]           rem_ff, rem_in, limb_rem_ff, limb_rem_in;
   logic                 sticky_ff, sticky_in;
   logic                 div_a_ff, div_a_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic [127:0]         ld_a_ext, ld_b_ext;
   logic [SW-1:0]        ld_sa, ld_sb;
   logic                 eq, mul_a, div_a;
   logic [MANT_BITS-1:0] mul_src;
   logic [MANT_BITS+3:0] mul_ext, mul_prod;
   logic                 mul_fits;
   logic [PAD_W-1:0]     div_pad, div_pad_next;
   logic [31:0]          limb, q_limb;
   logic [32:0]          limb_t;
   logic [64:0]          recip_prod;
   logic [29:0]          q_small;
   logic [3:0]           limb_rem_new;
   logic [MANT_BITS-1:0] rnd_src;
   logic                 rnd_up;
   logic [31:0]          scale_wide;

   assign ld_a_ext = {32'd0, in_mant_a_hi, in_mant_a_lo};
   assign ld_b_ext = {32'd0, in_mant_b_hi, in_mant_b_lo};
   assign ld_sa = (32'(in_scale_a) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(in_scale_a);
   assign ld_sb = (32'(in_scale_b) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(in_scale_b);

   assign eq    = (scale_a_ff == scale_b_ff);
   assign mul_a = (scale_a_ff < scale_b_ff);
   assign div_a = (scale_a_ff > scale_b_ff);

   // times ten as 8x + 2x; any bit at or above MANT_BITS is an overflow
   assign mul_src  = mul_a ? mant_a_ff : mant_b_ff;
   assign mul_ext  = (MANT_BITS+4)'(mul_src);
   assign mul_prod = (mul_ext << 3) + (mul_ext << 1);
   assign mul_fits = ~|mul_prod[MANT_BITS+3:MANT_BITS];

   // one 32-bit limb of long division by ten per cycle, top limb first
   assign div_pad    = PAD_W'(div_a ? mant_a_ff : mant_b_ff);
   assign limb       = div_pad[idx_ff*32 +: 32];
   assign limb_t     = 33'(limb) + 33'({limb_rem_ff, 2'b00}) + 33'({limb_rem_ff, 1'b0});
   assign recip_prod = 65'(limb_t) * 65'(DIV10_RECIP);
   assign q_small    = recip_prod[64:DIV10_SHIFT];
   assign q_limb     = 32'(36'(limb_rem_ff) * 36'(LIMB_Q)) + 32'(q_small);
   assign limb_rem_new = 4'(limb_t[3:0] - {q_small[0], 3'b000} - {q_small[2:0], 1'b0});

   always_comb begin
      div_pad_next = div_pad;
      div_pad_next[idx_ff*32 +: 32] = q_limb;
   end

   assign rnd_src = div_a_ff ? mant_a_ff : mant_b_ff;
   assign rnd_up  = (rem_ff > HALF_DIGIT) ||
                    ((rem_ff == HALF_DIGIT) && (sticky_ff || rnd_src[0]));

   always_comb begin
      mant_a_in   = mant_a_ff;
      mant_b_in   = mant_b_ff;
      orig_a_in   = orig_a_ff;
      orig_b_in   = orig_b_ff;
      scale_a_in  = scale_a_ff;
      scale_b_in  = scale_b_ff;
      orig_sa_in  = orig_sa_ff;
      orig_sb_in  = orig_sb_ff;
      sign_a_in   = sign_a_ff;
      sign_b_in   = sign_b_ff;
      ovf_in      = ovf_ff;
      rem_in      = rem_ff;
      limb_rem_in = limb_rem_ff;
      sticky_in   = sticky_ff;
      div_a_in    = div_a_ff;
      idx_in      = idx_ff;
      if (ctrl.fire) begin
         case (ctrl.op)
            OP_LOAD: begin
               mant_a_in   = ld_a_ext[MANT_BITS-1:0];
               mant_b_in   = ld_b_ext[MANT_BITS-1:0];
               orig_a_in   = ld_a_ext[MANT_BITS-1:0];
               orig_b_in   = ld_b_ext[MANT_BITS-1:0];
               scale_a_in  = ld_sa;
               scale_b_in  = ld_sb;
               orig_sa_in  = ld_sa;
               orig_sb_in  = ld_sb;
               sign_a_in   = in_sign_a;
               sign_b_in   = in_sign_b;
               ovf_in      = 1'b0;
               rem_in      = 4'd0;
               limb_rem_in = 4'd0;
               sticky_in   = 1'b0;
               div_a_in    = 1'b0;
               idx_in      = TOP_IDX;
            end
            OP_MUL: begin
               if (!eq) begin
                  if (mul_fits) begin
                     if (mul_a) begin
                        mant_a_in  = mul_prod[MANT_BITS-1:0];
                        scale_a_in = scale_a_ff + 1'b1;
                     end else begin
                        mant_b_in  = mul_prod[MANT_BITS-1:0];
                        scale_b_in = scale_b_ff + 1'b1;
                     end
                  end else begin
                     // restore both originals
                     mant_a_in  = orig_a_ff;
                     mant_b_in  = orig_b_ff;
                     scale_a_in = orig_sa_ff;
                     scale_b_in = orig_sb_ff;
                     ovf_in     = 1'b1;
                  end
               end
            end
            OP_DIV: begin
               if (!eq) begin
                  div_a_in = div_a;
                  if (div_a) begin
                     mant_a_in = div_pad_next[MANT_BITS-1:0];
                  end else begin
                     mant_b_in = div_pad_next[MANT_BITS-1:0];
                  end
                  if (idx_ff == '0) begin
                     // last limb: the digit is final, close the step
                     idx_in      = TOP_IDX;
                     limb_rem_in = 4'd0;
                     rem_in      = limb_rem_new;
                     sticky_in   = sticky_ff || (rem_ff != 4'd0);
                     if (div_a) begin
                        scale_a_in = scale_a_ff - 1'b1;
                     end else begin
                        scale_b_in = scale_b_ff - 1'b1;
                     end
                  end else begin
                     idx_in      = idx_ff - 1'b1;
                     limb_rem_in = limb_rem_new;
                  end
               end
            end
            OP_ROUND: begin
               if (rnd_up) begin
                  if (div_a_ff) begin
                     mant_a_in = mant_a_ff + 1'b1;
                  end else begin
                     mant_b_in = mant_b_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mant_a_ff   <= mant_a_in;
      mant_b_ff   <= mant_b_in;
      orig_a_ff   <= orig_a_in;
      orig_b_ff   <= orig_b_in;
      scale_a_ff  <= scale_a_in;
      scale_b_ff  <= scale_b_in;
      orig_sa_ff  <= orig_sa_in;
      orig_sb_ff  <= orig_sb_in;
      sign_a_ff   <= sign_a_in;
      sign_b_ff   <= sign_b_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      limb_rem_ff <= limb_rem_in;
      sticky_ff   <= sticky_in;
      div_a_ff    <= div_a_in;
      idx_ff      <= idx_in;
   end

   assign stat.eq      = eq;
   assign stat.mul_ovf = (ctrl.op == OP_MUL) && !eq && !mul_fits;
   assign stat.ovf     = ovf_ff;

   assign scale_wide = 32'(scale_a_ff);
   assign res_mant_a = mant_a_ff;
   assign res_mant_b = mant_b_ff;
   assign res_scale  = scale_wide[4:0];
   assign res_sign_a = sign_a_ff;
   assign res_sign_b = sign_b_ff;

endmodule

`default_nettype wire

/* dv/tb_decimal_scale_align_top.sv */
`default_nettype none

module tb_decimal_scale_align_top;

   localparam int MANT_BITS    = 96;
   localparam int MAX_SCALE    = 28;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_ITEMS  = 200;
   localparam int DRAIN_CYCLES = 160;
   localparam int LIMIT_CYCLES = 1_500_000;

   localparam logic [31:0] ALL_HI = 32'hFFFF_FFFF;
   localparam logic [63:0] ALL_LO = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] mant_a_hi;
      logic [63:0] mant_a_lo;
      logic [4:0]  scale_a;
      logic        sign_a;
      logic [31:0] mant_b_hi;
      logic [63:0] mant_b_lo;
      logic [4:0]  scale_b;
      logic        sign_b;
   } operand_pair_type;

   typedef struct packed {
      logic [31:0] out_a_hi;
      logic [63:0] out_a_lo;
      logic        out_a_sign;
      logic [31:0] out_b_hi;
      logic [63:0] out_b_lo;
      logic        out_b_sign;
      logic [4:0]  common_scale;
      logic        was_rounded;
   } aligned_pair_type;

   typedef struct {
      operand_pair_type op;
      bit               typed;
      aligned_pair_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_mant_a_lo;
   logic [31:0] req_mant_a_hi;
   logic [4:0]  req_scale_a;
   logic        req_sign_a;
   logic [63:0] req_mant_b_lo;
   logic [31:0] req_mant_b_hi;
   logic [4:0]  req_scale_b;
   logic        req_sign_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_out_a_lo;
   logic [31:0] rsp_out_a_hi;
   logic        rsp_out_a_sign;
   logic [63:0] rsp_out_b_lo;
   logic [31:0] rsp_out_b_hi;
   logic        rsp_out_b_sign;
   logic [4:0]  rsp_common_scale;
   logic        rsp_was_rounded;

   aligned_pair_type aligned_due[$];
   stim_row_type     directed_rows[22];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               quiet_tail = 1'b0;

   decimal_scale_align_top #(
      .MANT_BITS(MANT_BITS),
      .MAX_SCALE(MAX_SCALE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mant_a_lo(req_mant_a_lo),
      .req_mant_a_hi(req_mant_a_hi),
      .req_scale_a(req_scale_a),
      .req_sign_a(req_sign_a),
      .req_mant_b_lo(req_mant_b_lo),
      .req_mant_b_hi(req_mant_b_hi),
      .req_scale_b(req_scale_b),
      .req_sign_b(req_sign_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_a_lo(rsp_out_a_lo),
      .rsp_out_a_hi(rsp_out_a_hi),
      .rsp_out_a_sign(rsp_out_a_sign),
      .rsp_out_b_lo(rsp_out_b_lo),
      .rsp_out_b_hi(rsp_out_b_hi),
      .rsp_out_b_sign(rsp_out_b_sign),
      .rsp_common_scale(rsp_common_scale),
      .rsp_was_rounded(rsp_was_rounded)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scale up the smaller-scale side; on overflow restore both and divide the
   // larger-scale side down instead, rounding half to even with a sticky digit.
   function automatic aligned_pair_type align_operands(input operand_pair_type op);
      aligned_pair_type res;
      logic [95:0]      ma, mb;
      logic [99:0]      prod;
      logic [4:0]       sa, sb, ia, ib;
      logic [3:0]       digit;
      logic             ovf, sticky, from_a, up;
      ma = {op.mant_a_hi, op.mant_a_lo};
      mb = {op.mant_b_hi, op.mant_b_lo};
      sa = (op.scale_a > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : op.scale_a;
      sb = (op.scale_b > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : op.scale_b;
      ia = sa;
      ib = sb;
      ovf = 1'b0;
      while (sa != sb && !ovf) begin
         prod = {4'd0, (sa < sb) ? ma : mb} * 100'd10;
         if (prod[99:96] != 4'd0) begin
            ovf = 1'b1;
         end else if (sa < sb) begin
            ma = prod[95:0];
            sa = sa + 5'd1;
         end else begin
            mb = prod[95:0];
            sb = sb + 5'd1;
         end
      end
      if (ovf) begin
         ma = {op.mant_a_hi, op.mant_a_lo};
         mb = {op.mant_b_hi, op.mant_b_lo};
         sa = ia;
         sb = ib;
         digit = 4'd0;
         sticky = 1'b0;
         from_a = 1'b0;
         while (sa != sb) begin
            if (digit != 4'd0) sticky = 1'b1;
            if (sa > sb) begin
               from_a = 1'b1;
               digit = 4'(ma % 96'd10);
               ma = ma / 96'd10;
               sa = sa - 5'd1;
            end else begin
               from_a = 1'b0;
               digit = 4'(mb % 96'd10);
               mb = mb / 96'd10;
               sb = sb - 5'd1;
            end
         end
         up = (digit > 4'd5) ||
              (digit == 4'd5 && (sticky || (from_a ? ma[0] : mb[0])));
         if (up && from_a) ma = ma + 96'd1;
         if (up && !from_a) mb = mb + 96'd1;
      end
      {res.out_a_hi, res.out_a_lo} = ma;
      {res.out_b_hi, res.out_b_lo} = mb;
      res.out_a_sign = op.sign_a;
      res.out_b_sign = op.sign_b;
      res.common_scale = sa;
      res.was_rounded = ovf;
      return res;
   endfunction

   function automatic logic [95:0] random_mantissa();
      logic [95:0] m;
      int          steps;
      case ($urandom_range(0, 9))
         0: m = '1;
         1: m = 96'($urandom_range(0, 1000));
         2: begin
            // a trailing five, possibly followed by zeros: exercises the tie
            m = 96'($urandom_range(0, 99999)) * 96'd10 + 96'd5;
            steps = $urandom_range(0, 4);
            repeat (steps) m = m * 96'd10;
         end
         3, 4: m = {$urandom, $urandom, $urandom};
         5: begin
            // sit on the edge where a multiply by ten stops fitting
            m = '1;
            steps = $urandom_range(1, 28);
            repeat (steps) m = m / 96'd10;
            m = m + 96'($urandom_range(0, 1));
         end
         default: m = {$urandom, $urandom, $urandom} >> $urandom_range(1, 95);
      endcase
      return m;
   endfunction

   function automatic logic [4:0] random_scale();
      if ($urandom_range(0, 7) == 0) return 5'($urandom_range(29, 31));
      return 5'($urandom_range(0, MAX_SCALE));
   endfunction

   task automatic send_pair(input operand_pair_type op, input aligned_pair_type want);
      int gap;
      gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mant_a_lo <= op.mant_a_lo;
      req_mant_a_hi <= op.mant_a_hi;
      req_scale_a   <= op.scale_a;
      req_sign_a    <= op.sign_a;
      req_mant_b_lo <= op.mant_b_lo;
      req_mant_b_hi <= op.mant_b_hi;
      req_scale_b   <= op.scale_b;
      req_sign_b    <= op.sign_b;
      do @(posedge clock); while (req_stall);
      aligned_due.push_back(want);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin : stimulus
      operand_pair_type op;
      aligned_pair_type want;
      int               n;
      directed_rows = '{
         '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
         '{'{ALL_HI, ALL_LO, 28, 1, ALL_HI, ALL_LO, 28, 1}, 1'b1,
           '{ALL_HI, ALL_LO, 1, ALL_HI, ALL_LO, 1, 28, 0}},
         '{'{0, 5, 31, 0, 0, 7, 29, 1}, 1'b1, '{0, 5, 0, 0, 7, 1, 28, 0}},
         '{'{0, 1, 0, 0, 0, 1, 28, 0}, 1'b0, '0},
         '{'{0, 1, 28, 1, 0, 1, 0, 1}, 1'b0, '0},
         '{'{0, 1, 31, 0, 0, 3, 0, 1}, 1'b0, '0},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 0, 1, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 0, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 15, 1, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 2, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 25, 1, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 2, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 26, 1, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 3, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 24, 1, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 2, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 1250, 2, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 12, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 1251, 2, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 13, 0, 0, 1}},
         '{'{ALL_HI, ALL_LO, 0, 0, 0, 1350, 2, 0}, 1'b1,
           '{ALL_HI, ALL_LO, 0, 0, 14, 0, 0, 1}},
         '{'{0, 35, 1, 1, ALL_HI, ALL_LO, 0, 0}, 1'b1,
           '{0, 4, 1, ALL_HI, ALL_LO, 0, 0, 1}},
         '{'{0, 45, 1, 0, ALL_HI, ALL_LO, 0, 1}, 1'b1,
           '{0, 4, 0, ALL_HI, ALL_LO, 1, 0, 1}},
         '{'{ALL_HI, ALL_LO, 28, 1, ALL_HI, ALL_LO, 0, 0}, 1'b0, '0},
         '{'{ALL_HI, ALL_LO, 0, 0, ALL_HI, ALL_LO, 28, 1}, 1'b0, '0},
         '{'{32'h0FFF_FFFF, ALL_LO, 0, 0, 0, 1, 5, 0}, 1'b0, '0},
         '{'{32'h1999_9999, 64'h9999_9999_9999_9999, 0, 0, 0, 0, 1, 0}, 1'b1,
           '{ALL_HI, 64'hFFFF_FFFF_FFFF_FFFA, 0, 0, 0, 0, 1, 0}},
         '{'{32'h1999_9999, 64'h9999_9999_9999_999A, 0, 0, 0, 0, 1, 0}, 1'b1,
           '{32'h1999_9999, 64'h9999_9999_9999_999A, 0, 0, 0, 0, 0, 1}},
         '{'{32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 7, 1,
             32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 7, 0}, 1'b1,
           '{32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 1,
             32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 7, 0}}
      };
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mant_a_lo <= '0;
      req_mant_a_hi <= '0;
      req_scale_a   <= '0;
      req_sign_a    <= 1'b0;
      req_mant_b_lo <= '0;
      req_mant_b_hi <= '0;
      req_scale_b   <= '0;
      req_sign_b    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed ? directed_rows[i].want
                                       : align_operands(directed_rows[i].op);
         send_pair(directed_rows[i].op, want);
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         {op.mant_a_hi, op.mant_a_lo} = random_mantissa();
         {op.mant_b_hi, op.mant_b_lo} = random_mantissa();
         op.scale_a = random_scale();
         op.scale_b = random_scale();
         op.sign_a = 1'($urandom_range(0, 1));
         op.sign_b = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) op.scale_b = op.scale_a;
         send_pair(op, align_operands(op));
      end
      req_valid <= 1'b0;
      while (aligned_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_decimal_scale_align_top: clean");
      end else begin
         $display("tb_decimal_scale_align_top: errors");
      end
      $finish;
   end

   // Hold the result channel in bursts; leave long clean runs now and then.
   initial begin : rsp_stall_gen
      int run;
      forever begin
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
            run = 1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 14);
         end else begin
            rsp_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(1, 20);
         end
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      aligned_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (aligned_due.size() == 0) begin
            $error("result beat with nothing outstanding");
            mismatch_count++;
         end else begin
            want = aligned_due.pop_front();
            check_field("out_a_lo", want.out_a_lo, rsp_out_a_lo);
            check_field("out_a_hi", 64'(want.out_a_hi), 64'(rsp_out_a_hi));
            check_field("out_a_sign", 64'(want.out_a_sign), 64'(rsp_out_a_sign));
            check_field("out_b_lo", want.out_b_lo, rsp_out_b_lo);
            check_field("out_b_hi", 64'(want.out_b_hi), 64'(rsp_out_b_hi));
            check_field("out_b_sign", 64'(want.out_b_sign), 64'(rsp_out_b_sign));
            check_field("common_scale", 64'(want.common_scale), 64'(rsp_common_scale));
            check_field("was_rounded", 64'(want.was_rounded), 64'(rsp_was_rounded));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_decimal_scale_align_top: errors");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/dsa_pkg.sv
rtl/dsa_datapath.sv
rtl/decimal_scale_align_top.sv
dv/tb_decimal_scale_align_top.sv
